[sv/rbn_pkg.sv]
// ----------------------------------------------------------------------------
// rbn_pkg: shared constants for the rotation-between-normals pipeline
// Field widths, fixed-point scale and the sizes of the root and divide units.
// ----------------------------------------------------------------------------
package rbn_pkg;

	localparam int IN_W    = 16;     // one vector component
	localparam int OUT_W   = 16;     // one matrix entry, Q1.14
	localparam int NUM_IN  = 6;
	localparam int NUM_OUT = 9;
	localparam int ONE_Q14 = 16384;

	// square root units: radicand width, result is half of it
	localparam int ROOT_WIDE_W   = 64;
	localparam int ROOT_NARROW_W = 30;

	// rounding divider: numerator, doubled denominator, quotient bits
	localparam int DIV_NUM_W = 48;
	localparam int DIV_DEN_W = 33;
	localparam int DIV_QUO_W = 15;

endpackage

[sv/rbn_delay.sv]
// ----------------------------------------------------------------------------
// rbn_delay: stallable delay line
// Carries side data alongside the root and divide units, one tap per stage.
// ----------------------------------------------------------------------------
module rbn_delay #(
	parameter int W     = 1,
	parameter int DEPTH = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);

	logic [W-1:0] tap_s [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			tap_s[0] <= din;
			for (int i = 1; i < DEPTH; i++) begin
				tap_s[i] <= tap_s[i-1];
			end
		end
	end

	assign dout = tap_s[DEPTH-1];

endmodule

[sv/rbn_root.sv]
// ----------------------------------------------------------------------------
// rbn_root: pipelined integer square root
// Floor of the square root, one result bit per stage, W/2 stages.
// ----------------------------------------------------------------------------
module rbn_root #(
	parameter int W = rbn_pkg::ROOT_WIDE_W
) (
	input  logic           clk,
	input  logic           en,
	input  logic [W-1:0]   rad,
	output logic [W/2-1:0] root
);

	localparam int STEPS = W / 2;

	logic [W-1:0] rem_s [STEPS];
	logic [W-1:0] acc_s [STEPS];

	for (genvar j = 0; j < STEPS; j++) begin : g_step
		localparam logic [W:0] BIT = (W+1)'(1) << (W - 2 - 2 * j);
		logic [W-1:0] v_in;
		logic [W-1:0] r_in;
		logic [W:0]   trial;

		if (j == 0) begin : g_first
			assign v_in = rad;
			assign r_in = '0;
		end else begin : g_next
			assign v_in = rem_s[j-1];
			assign r_in = acc_s[j-1];
		end

		assign trial = {1'b0, r_in} + BIT;

		always_ff @(posedge clk) begin
			if (en) begin
				if ({1'b0, v_in} >= trial) begin
					rem_s[j] <= W'({1'b0, v_in} - trial);
					acc_s[j] <= W'(({1'b0, r_in} >> 1) + BIT);
				end else begin
					rem_s[j] <= v_in;
					acc_s[j] <= r_in >> 1;
				end
			end
		end
	end

	assign root = acc_s[STEPS-1][W/2-1:0];

endmodule

[sv/rbn_div.sv]
// ----------------------------------------------------------------------------
// rbn_div: pipelined restoring divider
// Unsigned num / den, one quotient bit per stage, QW stages.
// ----------------------------------------------------------------------------
module rbn_div #(
	parameter int NW = rbn_pkg::DIV_NUM_W,
	parameter int DW = rbn_pkg::DIV_DEN_W,
	parameter int QW = rbn_pkg::DIV_QUO_W
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo
);

	logic [NW-1:0] rem_s [QW];
	logic [DW-1:0] dv_s  [QW];
	logic [QW-1:0] q_s   [QW];

	for (genvar j = 0; j < QW; j++) begin : g_step
		localparam int K = QW - 1 - j;
		logic [NW-1:0] r_in;
		logic [DW-1:0] d_in;
		logic [QW-1:0] q_in;
		logic [NW-1:0] sh;

		if (j == 0) begin : g_first
			assign r_in = num;
			assign d_in = den;
			assign q_in = '0;
		end else begin : g_next
			assign r_in = rem_s[j-1];
			assign d_in = dv_s[j-1];
			assign q_in = q_s[j-1];
		end

		assign sh = NW'(d_in) << K;

		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[j] <= d_in;
				if (r_in >= sh) begin
					rem_s[j] <= r_in - sh;
					q_s[j]   <= q_in | (QW'(1) << K);
				end else begin
					rem_s[j] <= r_in;
					q_s[j]   <= q_in;
				end
			end
		end
	end

	assign quo = q_s[QW-1];

endmodule

[sv/rotation_between_normals_top.sv]
// ----------------------------------------------------------------------------
// rotation_between_normals_top: Rodrigues rotation between two normals
// Cosine, sine and unit axis from a base normal and a negated turn normal,
// then the 3x3 rotation matrix in Q1.14, with a flag for an undefined axis.
// ----------------------------------------------------------------------------
// One word in per clock while tready is high, one word out per input word. A
// word accepted passes 76 register stages on its way to the output: unpack
// and negate, 4 product and sum stages, two 32-step square root pipelines
// side by side (norm product and cross product), a divide operand stage,
// 15-step rounding dividers for cosine and axis, a sign stage, 2 stages for
// 1 - c*c, a 15-step root for the sine, 4 matrix stages and the output
// register. A one-word skid behind the output register keeps the pipeline
// moving while a result waits; tready drops only when that skid is full.
module rotation_between_normals_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// base_x, base_y, base_z, turn_x, turn_y, turn_z
	input  logic [rbn_pkg::NUM_IN*rbn_pkg::IN_W-1:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// m00, m01, m02, m10, m11, m12, m20, m21, m22
	output logic [rbn_pkg::NUM_OUT*rbn_pkg::OUT_W-1:0] m_axis_tdata,
	// degenerate
	output logic         m_axis_tuser
);

	localparam int IW      = rbn_pkg::IN_W;
	localparam int OW      = rbn_pkg::OUT_W;
	localparam int OUT_BUS = rbn_pkg::NUM_OUT * OW;
	localparam int LAST    = 75;
	localparam int DLY_A   = rbn_pkg::ROOT_WIDE_W / 2 + 1;
	localparam int DLY_B   = rbn_pkg::DIV_QUO_W;
	localparam int DLY_C   = rbn_pkg::ROOT_NARROW_W / 2 + 2;
	localparam int A_W     = 35 + 3 * 33 + 2;
	localparam int C_W     = 4 * OW + 2;

	logic en;
	logic [LAST:1] vld_s;
	logic skid_vld_q, out_vld_q;
	logic [OUT_BUS:0] skid_data_q, out_data_q, pay;

	assign en = !skid_vld_q;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAST-1:1], s_axis_tvalid};
		end
	end

	// s1: unpack, negate turn normal
	logic signed [15:0] b_s1 [3];
	logic signed [16:0] n_s1 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				b_s1[i] <= $signed(s_axis_tdata[IW*i +: IW]);
				n_s1[i] <= -$signed({s_axis_tdata[IW*(3+i)+IW-1], s_axis_tdata[IW*(3+i) +: IW]});
			end
		end
	end

	// s2: component products
	logic signed [32:0] pdot_s2 [3];
	logic signed [32:0] pnn_s2 [3];
	logic signed [32:0] pbb_s2 [3];
	logic signed [32:0] pcr_s2 [6];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pdot_s2[i] <= 33'(n_s1[i]) * 33'(b_s1[i]);
				pnn_s2[i]  <= 33'(n_s1[i]) * 33'(n_s1[i]);
				pbb_s2[i]  <= 33'(b_s1[i]) * 33'(b_s1[i]);
			end
			pcr_s2[0] <= 33'(n_s1[1]) * 33'(b_s1[2]);
			pcr_s2[1] <= 33'(n_s1[2]) * 33'(b_s1[1]);
			pcr_s2[2] <= 33'(n_s1[2]) * 33'(b_s1[0]);
			pcr_s2[3] <= 33'(n_s1[0]) * 33'(b_s1[2]);
			pcr_s2[4] <= 33'(n_s1[0]) * 33'(b_s1[1]);
			pcr_s2[5] <= 33'(n_s1[1]) * 33'(b_s1[0]);
		end
	end

	// s3: dot, squared norms, cross product
	logic signed [34:0] dot_s3;
	logic [31:0] nn_s3, bb_s3;
	logic signed [32:0] cr_s3 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			dot_s3   <= 35'(pdot_s2[0]) + 35'(pdot_s2[1]) + 35'(pdot_s2[2]);
			nn_s3    <= 32'(pnn_s2[0] + pnn_s2[1] + pnn_s2[2]);
			bb_s3    <= 32'(pbb_s2[0] + pbb_s2[1] + pbb_s2[2]);
			cr_s3[0] <= pcr_s2[0] - pcr_s2[1];
			cr_s3[1] <= pcr_s2[2] - pcr_s2[3];
			cr_s3[2] <= pcr_s2[4] - pcr_s2[5];
		end
	end

	// s4: norm product, squared cross terms, special-case flags
	logic [31:0] crm3 [3];
	logic zero3;
	logic [63:0] nnbb_s4, crsq_s4 [3];
	logic signed [34:0] dot_s4;
	logic signed [32:0] cr_s4 [3];
	logic deg_s4, cneg_s4;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			crm3[i] = 32'(cr_s3[i][32] ? -cr_s3[i] : cr_s3[i]);
		end
	end
	assign zero3 = (nn_s3 == '0) || (bb_s3 == '0);

	always_ff @(posedge clk) begin
		if (en) begin
			nnbb_s4 <= 64'(nn_s3) * 64'(bb_s3);
			for (int i = 0; i < 3; i++) begin
				crsq_s4[i] <= 64'(crm3[i]) * 64'(crm3[i]);
				cr_s4[i]   <= cr_s3[i];
			end
			dot_s4  <= dot_s3;
			deg_s4  <= zero3 || (cr_s3[0] == '0 && cr_s3[1] == '0 && cr_s3[2] == '0);
			cneg_s4 <= !zero3 && dot_s3[34];
		end
	end

	// s5: squared cross norm
	logic [63:0] nnbb_s5, cc_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			nnbb_s5 <= nnbb_s4;
			cc_s5   <= crsq_s4[0] + crsq_s4[1] + crsq_s4[2];
		end
	end

	// s6..s37: two square roots, side data alongside
	logic [31:0] den_c, den_a;
	logic [A_W-1:0] a_din, a_dout;

	rbn_root #(.W(rbn_pkg::ROOT_WIDE_W)) u_root_c (
		.clk(clk), .en(en), .rad(nnbb_s5), .root(den_c)
	);
	rbn_root #(.W(rbn_pkg::ROOT_WIDE_W)) u_root_a (
		.clk(clk), .en(en), .rad(cc_s5), .root(den_a)
	);

	assign a_din = {dot_s4, cr_s4[0], cr_s4[1], cr_s4[2], deg_s4, cneg_s4};

	rbn_delay #(.W(A_W), .DEPTH(DLY_A)) u_dly_a (
		.clk(clk), .en(en), .din(a_din), .dout(a_dout)
	);

	logic signed [34:0] dot_37;
	logic signed [32:0] cr_37 [3];
	logic [34:0] dota;
	logic [32:0] cra [3];

	assign dot_37   = $signed(a_dout[A_W-1 -: 35]);
	assign cr_37[0] = $signed(a_dout[2+66 +: 33]);
	assign cr_37[1] = $signed(a_dout[2+33 +: 33]);
	assign cr_37[2] = $signed(a_dout[2 +: 33]);
	assign dota     = dot_37[34] ? 35'(-dot_37) : 35'(dot_37);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cra[i] = cr_37[i][32] ? 33'(-cr_37[i]) : 33'(cr_37[i]);
		end
	end

	// s38: rounding-divide operands: (2^15|x| + d) / (2d)
	logic [47:0] nc_s38, na_s38 [3];
	logic [32:0] dc_s38, da_s38;
	logic [5:0]  b_din, b_dout;

	always_ff @(posedge clk) begin
		if (en) begin
			nc_s38 <= ({16'd0, dota[31:0]} << 15) + {16'd0, den_c};
			dc_s38 <= {den_c, 1'b0};
			for (int i = 0; i < 3; i++) begin
				na_s38[i] <= ({16'd0, cra[i][31:0]} << 15) + {16'd0, den_a};
			end
			da_s38 <= {den_a, 1'b0};
			b_din  <= {dot_37[34], cr_37[0][32], cr_37[1][32], cr_37[2][32], a_dout[1:0]};
		end
	end

	// s39..s53: dividers
	logic [14:0] qc, qa [3];

	rbn_div u_div_c (
		.clk(clk), .en(en), .num(nc_s38), .den(dc_s38), .quo(qc)
	);
	for (genvar i = 0; i < 3; i++) begin : g_div_a
		rbn_div u_div_a (
			.clk(clk), .en(en), .num(na_s38[i]), .den(da_s38), .quo(qa[i])
		);
	end

	rbn_delay #(.W(6), .DEPTH(DLY_B)) u_dly_b (
		.clk(clk), .en(en), .din(b_din), .dout(b_dout)
	);

	// s54: signed cosine and axis
	logic signed [15:0] c_s54, a_s54 [3];
	logic deg_s54, cneg_s54;

	always_ff @(posedge clk) begin
		if (en) begin
			c_s54 <= b_dout[5] ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
			for (int i = 0; i < 3; i++) begin
				a_s54[i] <= b_dout[4-i] ? -$signed({1'b0, qa[i]}) : $signed({1'b0, qa[i]});
			end
			deg_s54  <= b_dout[1];
			cneg_s54 <= b_dout[0];
		end
	end

	// s55, s56: 1 - c*c
	logic signed [31:0] csq_full;
	logic [28:0] csq_s55;
	logic [29:0] sv_s56;

	assign csq_full = 32'(c_s54) * 32'(c_s54);

	always_ff @(posedge clk) begin
		if (en) begin
			csq_s55 <= csq_full[28:0];
			sv_s56  <= 30'(rbn_pkg::ONE_Q14 * rbn_pkg::ONE_Q14) - 30'(csq_s55);
		end
	end

	// s57..s71: sine
	logic [14:0] sin_q;
	logic [C_W-1:0] c_din, c_dout;

	rbn_root #(.W(rbn_pkg::ROOT_NARROW_W)) u_root_s (
		.clk(clk), .en(en), .rad(sv_s56), .root(sin_q)
	);

	assign c_din = {a_s54[0], a_s54[1], a_s54[2], c_s54, deg_s54, cneg_s54};

	rbn_delay #(.W(C_W), .DEPTH(DLY_C)) u_dly_c (
		.clk(clk), .en(en), .din(c_din), .dout(c_dout)
	);

	logic signed [15:0] ax71, ay71, az71, c71, sn71;

	assign ax71 = $signed(c_dout[2+3*OW +: OW]);
	assign ay71 = $signed(c_dout[2+2*OW +: OW]);
	assign az71 = $signed(c_dout[2+OW +: OW]);
	assign c71  = $signed(c_dout[2 +: OW]);
	assign sn71 = $signed({1'b0, sin_q});

	// s72: axis outer products, axis times sine
	logic signed [31:0] pa_s72 [6], as_s72 [3];
	logic signed [16:0] co_s72;
	logic signed [15:0] c_s72;
	logic deg_s72, cneg_s72;

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s72[0] <= 32'(ax71) * 32'(ax71);
			pa_s72[1] <= 32'(ay71) * 32'(ay71);
			pa_s72[2] <= 32'(az71) * 32'(az71);
			pa_s72[3] <= 32'(ax71) * 32'(ay71);
			pa_s72[4] <= 32'(ax71) * 32'(az71);
			pa_s72[5] <= 32'(ay71) * 32'(az71);
			as_s72[0] <= 32'(ax71) * 32'(sn71);
			as_s72[1] <= 32'(ay71) * 32'(sn71);
			as_s72[2] <= 32'(az71) * 32'(sn71);
			co_s72    <= 17'(rbn_pkg::ONE_Q14) - 17'(c71);
			c_s72     <= c71;
			deg_s72   <= c_dout[1];
			cneg_s72  <= c_dout[0];
		end
	end

	// s73: scale by 1 - c, align to Q42
	logic signed [47:0] ta_s73 [6], asq_s73 [3], cq_s73;
	logic deg_s73, cneg_s73;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 6; i++) begin
				ta_s73[i] <= 48'(pa_s72[i]) * 48'(co_s72);
			end
			for (int i = 0; i < 3; i++) begin
				asq_s73[i] <= 48'(as_s72[i]) <<< 14;
			end
			cq_s73   <= 48'(c_s72) <<< 28;
			deg_s73  <= deg_s72;
			cneg_s73 <= cneg_s72;
		end
	end

	// s74: matrix entries in Q42
	logic signed [47:0] m_s74 [9];
	logic deg_s74, cneg_s74;

	always_ff @(posedge clk) begin
		if (en) begin
			m_s74[0] <= ta_s73[0] + cq_s73;
			m_s74[1] <= ta_s73[3] - asq_s73[2];
			m_s74[2] <= ta_s73[4] + asq_s73[1];
			m_s74[3] <= ta_s73[3] + asq_s73[2];
			m_s74[4] <= ta_s73[1] + cq_s73;
			m_s74[5] <= ta_s73[5] - asq_s73[0];
			m_s74[6] <= ta_s73[4] - asq_s73[1];
			m_s74[7] <= ta_s73[5] + asq_s73[0];
			m_s74[8] <= ta_s73[2] + cq_s73;
			deg_s74  <= deg_s73;
			cneg_s74 <= cneg_s73;
		end
	end

	// s75: round to Q14, saturate, degenerate override
	logic [47:0] mag_c [9], rq_c [9];
	logic [15:0] r16_c [9], val_c [9], cdeg;
	logic [15:0] o_s75 [9];
	logic deg_s75;

	assign cdeg = cneg_s74 ? 16'(-rbn_pkg::ONE_Q14) : 16'(rbn_pkg::ONE_Q14);

	always_comb begin
		for (int k = 0; k < 9; k++) begin
			mag_c[k] = m_s74[k][47] ? 48'(-m_s74[k]) : 48'(m_s74[k]);
			rq_c[k]  = (mag_c[k] + 48'd134217728) >> 28;
			r16_c[k] = (rq_c[k] > 48'(rbn_pkg::ONE_Q14)) ? 16'(rbn_pkg::ONE_Q14) : rq_c[k][15:0];
			val_c[k] = m_s74[k][47] ? -r16_c[k] : r16_c[k];
			if (deg_s74) begin
				val_c[k] = (k == 0 || k == 4 || k == 8) ? cdeg : '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			o_s75   <= val_c;
			deg_s75 <= deg_s74;
		end
	end

	// output register with one-word skid
	logic new_vld;

	assign new_vld = vld_s[LAST] && en;
	assign pay = {deg_s75, o_s75[8], o_s75[7], o_s75[6], o_s75[5], o_s75[4],
		o_s75[3], o_s75[2], o_s75[1], o_s75[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (m_axis_tready || !out_vld_q) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= new_vld;
			end
		end else if (new_vld) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (m_axis_tready || !out_vld_q) begin
			if (skid_vld_q) begin
				out_data_q <= skid_data_q;
			end else if (new_vld) begin
				out_data_q <= pay;
			end
		end else if (new_vld) begin
			skid_data_q <= pay;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q[OUT_BUS-1:0];
	assign m_axis_tuser  = out_data_q[OUT_BUS];

`ifndef NO_ASSERTIONS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid holds a word while output register is empty");

	a_stall_fills_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !m_axis_tready && vld_s[LAST] && s_axis_tready) |=> skid_vld_q)
		else $error("word leaving the pipeline during a stall was dropped");

	a_deg_offdiag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[47:16] == '0 &&
		m_axis_tdata[63:48] == '0 && m_axis_tdata[127:80] == '0 &&
		m_axis_tdata[127:112] == '0))
		else $error("degenerate word has nonzero off-diagonal entries");
`endif

endmodule

[verif/rotation_between_normals_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_between_normals_checker: rotation matrix predictor and comparator
// Watches both stream channels, computes the expected matrix and degenerate
// flag for every accepted input word and compares it with each output word.
// ----------------------------------------------------------------------------
module rotation_between_normals_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	input  logic s_axis_tready,
	input  logic [rbn_pkg::NUM_IN*rbn_pkg::IN_W-1:0] s_axis_tdata,
	input  logic m_axis_tvalid,
	input  logic m_axis_tready,
	input  logic [rbn_pkg::NUM_OUT*rbn_pkg::OUT_W-1:0] m_axis_tdata,
	input  logic m_axis_tuser,
	output int   fail_count,
	output int   pending
);
	localparam int IN_W    = rbn_pkg::IN_W;
	localparam int OUT_W   = rbn_pkg::OUT_W;
	localparam int NUM_IN  = rbn_pkg::NUM_IN;
	localparam int NUM_OUT = rbn_pkg::NUM_OUT;
	localparam int ONE_Q14 = rbn_pkg::ONE_Q14;

	typedef struct {
		logic [NUM_OUT*OUT_W-1:0] mat;
		logic                     degen;
	} rotation_t;

	rotation_t rotation_q[$];

	function automatic logic [63:0] int_root(input logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// round to nearest, halves away from zero
	function automatic longint round_div(input longint num, input logic [63:0] den);
		logic [63:0] mag, q;
		mag = num < 0 ? -num : num;
		q = (2 * mag + den) / (2 * den);
		return num < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint clamp_q14(input longint v);
		if (v > ONE_Q14)
			return ONE_Q14;
		if (v < -ONE_Q14)
			return -ONE_Q14;
		return v;
	endfunction

	function automatic rotation_t predict_rotation(input logic [NUM_IN*IN_W-1:0] d);
		rotation_t res;
		longint b[3], n[3], cr[3], m[9], a[3];
		longint dot, c, s, co, cq;
		logic [63:0] nn, bb, cc, den;
		for (int i = 0; i < 3; i++) begin
			b[i] = longint'($signed(d[i*IN_W +: IN_W]));
			n[i] = -longint'($signed(d[(3+i)*IN_W +: IN_W]));
		end
		dot = n[0]*b[0] + n[1]*b[1] + n[2]*b[2];
		nn = n[0]*n[0] + n[1]*n[1] + n[2]*n[2];
		bb = b[0]*b[0] + b[1]*b[1] + b[2]*b[2];
		cr[0] = n[1]*b[2] - n[2]*b[1];
		cr[1] = n[2]*b[0] - n[0]*b[2];
		cr[2] = n[0]*b[1] - n[1]*b[0];
		res.mat = '0;
		if (nn == 0 || bb == 0 || (cr[0] == 0 && cr[1] == 0 && cr[2] == 0)) begin
			if (nn == 0 || bb == 0)
				c = ONE_Q14;
			else
				c = dot < 0 ? -ONE_Q14 : ONE_Q14;
			res.mat[0*OUT_W +: OUT_W] = c[OUT_W-1:0];
			res.mat[4*OUT_W +: OUT_W] = c[OUT_W-1:0];
			res.mat[8*OUT_W +: OUT_W] = c[OUT_W-1:0];
			res.degen = 1'b1;
			return res;
		end
		den = int_root(nn * bb);
		c = clamp_q14(round_div(dot * ONE_Q14, den));
		s = longint'(int_root(64'(longint'(ONE_Q14) * ONE_Q14 - c * c)));
		cc = cr[0]*cr[0] + cr[1]*cr[1] + cr[2]*cr[2];
		den = int_root(cc);
		for (int i = 0; i < 3; i++)
			a[i] = round_div(cr[i] * ONE_Q14, den);
		co = ONE_Q14 - c;
		cq = c * ONE_Q14 * ONE_Q14;
		m[0] = a[0]*a[0]*co + cq;
		m[1] = a[0]*a[1]*co - a[2]*s*ONE_Q14;
		m[2] = a[0]*a[2]*co + a[1]*s*ONE_Q14;
		m[3] = a[1]*a[0]*co + a[2]*s*ONE_Q14;
		m[4] = a[1]*a[1]*co + cq;
		m[5] = a[1]*a[2]*co - a[0]*s*ONE_Q14;
		m[6] = a[2]*a[0]*co - a[1]*s*ONE_Q14;
		m[7] = a[2]*a[1]*co + a[0]*s*ONE_Q14;
		m[8] = a[2]*a[2]*co + cq;
		for (int i = 0; i < 9; i++) begin
			c = clamp_q14(round_div(m[i], 64'd1 << 28));
			res.mat[i*OUT_W +: OUT_W] = c[OUT_W-1:0];
		end
		res.degen = 1'b0;
		return res;
	endfunction

	initial fail_count = 0;
	initial pending = 0;

	always @(posedge clk) begin
		rotation_t exp_rot;
		if (arst_n && s_axis_tvalid && s_axis_tready)
			rotation_q.insert(rotation_q.size(), predict_rotation(s_axis_tdata));
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (rotation_q.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("ERROR: unexpected output word %h deg %b",
						m_axis_tdata, m_axis_tuser);
			end else begin
				exp_rot = rotation_q.pop_front();
				for (int i = 0; i < NUM_OUT; i++) begin
					if (m_axis_tdata[i*OUT_W +: OUT_W] !== exp_rot.mat[i*OUT_W +: OUT_W]) begin
						fail_count++;
						if (fail_count <= 10)
							$display("ERROR: entry %0d expected %0d got %0d", i,
								$signed(exp_rot.mat[i*OUT_W +: OUT_W]),
								$signed(m_axis_tdata[i*OUT_W +: OUT_W]));
					end
				end
				if (m_axis_tuser !== exp_rot.degen) begin
					fail_count++;
					if (fail_count <= 10)
						$display("ERROR: degenerate expected %b got %b",
							exp_rot.degen, m_axis_tuser);
				end
			end
		end
		pending = rotation_q.size();
	end

endmodule

[verif/rotation_between_normals_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_between_normals_top_tb: stimulus and verdict
// Directed corner vectors (zero, parallel, antiparallel, full-scale), then
// random pairs with random idle bursts on both sides; a checker compares.
// ----------------------------------------------------------------------------
module rotation_between_normals_top_tb;
	localparam int IN_W    = rbn_pkg::IN_W;
	localparam int OUT_W   = rbn_pkg::OUT_W;
	localparam int NUM_IN  = rbn_pkg::NUM_IN;
	localparam int NUM_OUT = rbn_pkg::NUM_OUT;

	localparam int RANDOM_WORDS = 1750;
	localparam int LATENCY      = 76;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [NUM_IN*IN_W-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [NUM_OUT*OUT_W-1:0] m_axis_tdata;
	logic m_axis_tuser;
	int   fail_count;
	int   pending;
	bit   quiet;

	rotation_between_normals_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	rotation_between_normals_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("Test completed with failures");
		$finish;
	end

	// output back-pressure in random bursts
	initial begin
		int burst;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 18);
				m_axis_tready <= 1'b0;
				repeat (burst) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	function automatic logic [IN_W-1:0] rand_comp();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($urandom_range(0, 6)) - 16'd3;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_pair(input logic [NUM_IN*IN_W-1:0] d);
		int burst;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			burst = $urandom_range(1, 18);
			s_axis_tvalid <= 1'b0;
			repeat (burst) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= d;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	function automatic logic [NUM_IN*IN_W-1:0] pack(input logic [IN_W-1:0] bx, by, bz,
		tx, ty, tz);
		return {tz, ty, tx, bz, by, bx};
	endfunction

	initial begin
		logic [IN_W-1:0] v[3];
		int k;
		quiet = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_pair(pack(0, 0, 0, 0, 0, 0));
		send_pair(pack(0, 0, 0, 1, 2, 3));
		send_pair(pack(5, 6, 7, 0, 0, 0));
		send_pair(pack(1, 2, 3, 2, 4, 6));              // n = -t antiparallel to b
		send_pair(pack(1, 2, 3, -2, -4, -6));           // n parallel
		send_pair(pack(16'h8000, 0, 0, 16'h8000, 0, 0));
		send_pair(pack(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff));
		send_pair(pack(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
		send_pair(pack(16'h7fff, 0, 0, 0, 16'h7fff, 0));
		send_pair(pack(0, 0, 16'h7fff, 16'h8000, 0, 0));
		send_pair(pack(1, 0, 0, 0, 0, 1));
		send_pair(pack(16'h7fff, 16'h8000, 1, 16'hffff, 16'h7fff, 16'h8000));
		send_pair(pack(1, 1, 0, 16'hffff, 0, 0));
		send_pair(pack(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hfffe, 16'hffff));
		send_pair(pack(16'h5555, 16'haaaa, 16'h0f0f, 16'hf0f0, 16'h3333, 16'hcccc));

		for (k = 0; k < RANDOM_WORDS; k++) begin
			if (k == RANDOM_WORDS - 150)
				quiet = 1'b1;
			for (int i = 0; i < 3; i++)
				v[i] = rand_comp();
			case ($urandom_range(0, 9))
				0: send_pair(pack(v[0], v[1], v[2], -v[0], -v[1], -v[2]));
				1: send_pair(pack(v[0], v[1], v[2], v[0], v[1], v[2]));
				2: send_pair(pack(v[0], v[1], v[2], 0, 0, 0));
				default: send_pair(pack(v[0], v[1], v[2],
					rand_comp(), rand_comp(), rand_comp()));
			endcase
		end
		s_axis_tvalid <= 1'b0;

		k = 0;
		while (pending != 0 && k < 200000) begin
			@(posedge clk);
			k++;
		end
		repeat (LATENCY + 20) @(posedge clk);
		if (pending == 0 && fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

[sim.f]
sv/rbn_pkg.sv
sv/rbn_delay.sv
sv/rbn_root.sv
sv/rbn_div.sv
sv/rotation_between_normals_top.sv
verif/rotation_between_normals_checker.sv
verif/rotation_between_normals_top_tb.sv
